>>> hw/rtl/mur_pkg.sv
// Shared types and constants for the multichannel uart ring buffer unit:
// operation and status codes, controller state, command and status structs.
// No dependencies.
package mur_pkg;

  // default configuration
  localparam int DEF_CHANNELS = 4;
  localparam int DEF_RX_DEPTH = 256;
  localparam int DEF_TX_DEPTH = 256;

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int CHAN_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_RX_PUT = 3'd0,
    OP_RX_GET = 3'd1,
    OP_TX_PUT = 3'd2,
    OP_TX_GET = 3'd3,
    OP_REINIT = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // latch the accepted item and read both stores
    logic commit;  // update indices, write store, load the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_full;  // result register holds an item not yet taken
  } dp_stat_t;

endpackage

>>> hw/rtl/mur_ctrl.sv
// Controller state machine for the multichannel uart ring buffer unit.
// Sequences item load and commit; depends on mur_pkg.
module mur_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  mur_pkg::dp_stat_t stat,
  output mur_pkg::cmd_t     cmd
);

  mur_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mur_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      mur_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = mur_pkg::ST_EXEC;
        end
      end
      mur_pkg::ST_EXEC: begin
        // finish once the result register is free or being emptied
        if (!stat.out_full || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = mur_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mur_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/mur_datapath.sv
// Datapath for the multichannel uart ring buffer unit: byte stores,
// per-channel indices and fill counts, busy flags and result register.
// Depends on mur_pkg; driven by mur_ctrl commands.
module mur_datapath #(
  parameter int CHANNELS = mur_pkg::DEF_CHANNELS,
  parameter int RX_DEPTH = mur_pkg::DEF_RX_DEPTH,
  parameter int TX_DEPTH = mur_pkg::DEF_TX_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mur_pkg::cmd_t                 cmd,
  output mur_pkg::dp_stat_t             stat,
  input  logic [mur_pkg::OP_W-1:0]      in_op,
  input  logic [mur_pkg::CHAN_W-1:0]    in_channel,
  input  logic [mur_pkg::BYTE_W-1:0]    in_data_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mur_pkg::BYTE_W-1:0]    out_data_out,
  output logic [mur_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_send_valid,
  output logic [mur_pkg::COUNT_W-1:0]   out_rx_count,
  output logic [mur_pkg::COUNT_W-1:0]   out_tx_count
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RX_AW  = $clog2(RX_DEPTH);
  localparam int TX_AW  = $clog2(TX_DEPTH);
  localparam int RX_FW  = $clog2(RX_DEPTH + 1);
  localparam int TX_FW  = $clog2(TX_DEPTH + 1);
  localparam int RX_MAW = $clog2(CHANNELS * RX_DEPTH);
  localparam int TX_MAW = $clog2(CHANNELS * TX_DEPTH);
  localparam int RX_MD  = CHANNELS * RX_DEPTH;
  localparam int TX_MD  = CHANNELS * TX_DEPTH;

  // byte stores
  logic [mur_pkg::BYTE_W-1:0] rx_mem [RX_MD];
  logic [mur_pkg::BYTE_W-1:0] tx_mem [TX_MD];
  logic [mur_pkg::BYTE_W-1:0] rx_q_r, tx_q_r;

  // per-channel control state
  logic [RX_AW-1:0] rx_wr_r [CHANNELS];
  logic [RX_AW-1:0] rx_rd_r [CHANNELS];
  logic [RX_FW-1:0] rx_fill_r [CHANNELS];
  logic [TX_AW-1:0] tx_wr_r [CHANNELS];
  logic [TX_AW-1:0] tx_rd_r [CHANNELS];
  logic [TX_FW-1:0] tx_fill_r [CHANNELS];
  logic             tx_busy_r [CHANNELS];
  logic [RX_AW-1:0] rx_wr_nxt [CHANNELS];
  logic [RX_AW-1:0] rx_rd_nxt [CHANNELS];
  logic [RX_FW-1:0] rx_fill_nxt [CHANNELS];
  logic [TX_AW-1:0] tx_wr_nxt [CHANNELS];
  logic [TX_AW-1:0] tx_rd_nxt [CHANNELS];
  logic [TX_FW-1:0] tx_fill_nxt [CHANNELS];
  logic             tx_busy_nxt [CHANNELS];

  // latched item
  logic [mur_pkg::OP_W-1:0]   op_r;
  logic [mur_pkg::CHAN_W-1:0] ch_r;
  logic [mur_pkg::BYTE_W-1:0] byte_r;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  logic [mur_pkg::BYTE_W-1:0]   res_data_r, res_data_nxt;
  logic [mur_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                         res_send_r, res_send_nxt;
  logic [mur_pkg::COUNT_W-1:0]  res_rxc_r, res_rxc_nxt;
  logic [mur_pkg::COUNT_W-1:0]  res_txc_r, res_txc_nxt;

  logic            in_ch_ok, ch_ok;
  logic [CH_W-1:0] in_ch_idx, ch_idx;
  logic [RX_MAW-1:0] rx_raddr, rx_waddr;
  logic [TX_MAW-1:0] tx_raddr, tx_waddr;
  logic rx_we, tx_we;

  // channel range checks and indices
  always_comb begin
    in_ch_ok  = int'(in_channel) < CHANNELS;
    ch_ok     = int'(ch_r) < CHANNELS;
    in_ch_idx = in_ch_ok ? CH_W'(in_channel) : '0;
    ch_idx    = ch_ok ? CH_W'(ch_r) : '0;
  end

  // store addresses: read at the head of the addressed channel on load
  always_comb begin
    rx_raddr = RX_MAW'(int'(in_ch_idx) * RX_DEPTH + int'(rx_rd_r[in_ch_idx]));
    tx_raddr = TX_MAW'(int'(in_ch_idx) * TX_DEPTH + int'(tx_rd_r[in_ch_idx]));
    rx_waddr = RX_MAW'(int'(ch_idx) * RX_DEPTH + int'(rx_wr_r[ch_idx]));
    tx_waddr = TX_MAW'(int'(ch_idx) * TX_DEPTH + int'(tx_wr_r[ch_idx]));
  end

  // byte stores with registered read
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_waddr] <= byte_r;
    end
    if (tx_we) begin
      tx_mem[tx_waddr] <= byte_r;
    end
    if (cmd.load) begin
      rx_q_r <= rx_mem[rx_raddr];
      tx_q_r <= tx_mem[tx_raddr];
    end
  end

  // item operation and result
  always_comb begin
    rx_wr_nxt      = rx_wr_r;
    rx_rd_nxt      = rx_rd_r;
    rx_fill_nxt    = rx_fill_r;
    tx_wr_nxt      = tx_wr_r;
    tx_rd_nxt      = tx_rd_r;
    tx_fill_nxt    = tx_fill_r;
    tx_busy_nxt    = tx_busy_r;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    res_data_nxt   = '0;
    res_status_nxt = mur_pkg::STAT_OK;
    res_send_nxt   = 1'b0;
    if (ch_ok) begin
      case (mur_pkg::op_t'(op_r))
        mur_pkg::OP_RX_PUT: begin
          if (rx_fill_r[ch_idx] < RX_FW'(RX_DEPTH)) begin
            rx_we                 = cmd.commit;
            rx_wr_nxt[ch_idx]     = (int'(rx_wr_r[ch_idx]) == RX_DEPTH - 1) ? '0
                                  : rx_wr_r[ch_idx] + 1'b1;
            rx_fill_nxt[ch_idx]   = rx_fill_r[ch_idx] + 1'b1;
          end else begin
            res_status_nxt = mur_pkg::STAT_FULL;
          end
        end
        mur_pkg::OP_RX_GET: begin
          if (rx_fill_r[ch_idx] != '0) begin
            res_data_nxt          = rx_q_r;
            rx_rd_nxt[ch_idx]     = (int'(rx_rd_r[ch_idx]) == RX_DEPTH - 1) ? '0
                                  : rx_rd_r[ch_idx] + 1'b1;
            rx_fill_nxt[ch_idx]   = rx_fill_r[ch_idx] - 1'b1;
          end else begin
            res_status_nxt = mur_pkg::STAT_EMPTY;
          end
        end
        mur_pkg::OP_TX_PUT: begin
          if (tx_fill_r[ch_idx] < TX_FW'(TX_DEPTH)) begin
            tx_we                 = cmd.commit;
            tx_wr_nxt[ch_idx]     = (int'(tx_wr_r[ch_idx]) == TX_DEPTH - 1) ? '0
                                  : tx_wr_r[ch_idx] + 1'b1;
            if (tx_fill_r[ch_idx] == '0 && !tx_busy_r[ch_idx]) begin
              // idle transmitter on an empty queue: the new byte goes straight out
              tx_busy_nxt[ch_idx] = 1'b1;
              tx_rd_nxt[ch_idx]   = (int'(tx_rd_r[ch_idx]) == TX_DEPTH - 1) ? '0
                                  : tx_rd_r[ch_idx] + 1'b1;
              res_data_nxt        = byte_r;
              res_send_nxt        = 1'b1;
            end else begin
              tx_fill_nxt[ch_idx] = tx_fill_r[ch_idx] + 1'b1;
            end
          end else begin
            res_status_nxt = mur_pkg::STAT_FULL;
          end
        end
        mur_pkg::OP_TX_GET: begin
          if (tx_fill_r[ch_idx] != '0) begin
            res_data_nxt          = tx_q_r;
            res_send_nxt          = 1'b1;
            tx_rd_nxt[ch_idx]     = (int'(tx_rd_r[ch_idx]) == TX_DEPTH - 1) ? '0
                                  : tx_rd_r[ch_idx] + 1'b1;
            tx_fill_nxt[ch_idx]   = tx_fill_r[ch_idx] - 1'b1;
          end else begin
            res_status_nxt      = mur_pkg::STAT_EMPTY;
            tx_busy_nxt[ch_idx] = 1'b0;
          end
        end
        mur_pkg::OP_REINIT: begin
          rx_wr_nxt[ch_idx]   = '0;
          rx_rd_nxt[ch_idx]   = '0;
          rx_fill_nxt[ch_idx] = '0;
          tx_wr_nxt[ch_idx]   = '0;
          tx_rd_nxt[ch_idx]   = '0;
          tx_fill_nxt[ch_idx] = '0;
          tx_busy_nxt[ch_idx] = 1'b0;
        end
        default: begin
          // unused codes leave the channel untouched
        end
      endcase
      res_rxc_nxt = mur_pkg::COUNT_W'(rx_fill_nxt[ch_idx]);
      res_txc_nxt = mur_pkg::COUNT_W'(tx_fill_nxt[ch_idx]);
    end else begin
      res_rxc_nxt = '0;
      res_txc_nxt = '0;
    end
  end

  // result handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        rx_wr_r[c]   <= '0;
        rx_rd_r[c]   <= '0;
        rx_fill_r[c] <= '0;
        tx_wr_r[c]   <= '0;
        tx_rd_r[c]   <= '0;
        tx_fill_r[c] <= '0;
        tx_busy_r[c] <= 1'b0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.commit) begin
        rx_wr_r   <= rx_wr_nxt;
        rx_rd_r   <= rx_rd_nxt;
        rx_fill_r <= rx_fill_nxt;
        tx_wr_r   <= tx_wr_nxt;
        tx_rd_r   <= tx_rd_nxt;
        tx_fill_r <= tx_fill_nxt;
        tx_busy_r <= tx_busy_nxt;
      end
    end
  end

  // item and result payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      ch_r   <= in_channel;
      byte_r <= in_data_in;
    end
    if (cmd.commit) begin
      res_data_r   <= res_data_nxt;
      res_status_r <= res_status_nxt;
      res_send_r   <= res_send_nxt;
      res_rxc_r    <= res_rxc_nxt;
      res_txc_r    <= res_txc_nxt;
    end
  end

  assign stat.out_full  = out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_data_out   = res_data_r;
  assign out_status     = res_status_r;
  assign out_send_valid = res_send_r;
  assign out_rx_count   = res_rxc_r;
  assign out_tx_count   = res_txc_r;

endmodule

>>> hw/rtl/multichannel_uart_ring_buffers_unit.sv
// Multichannel uart receive/transmit ring buffers, top level.
// Each accepted item is latched and its store entry read, then it is committed
// into the result register; a new item is taken only once the last is committed.
// A result may wait in the output register while the next item is taken;
// that item then stalls in commit until the waiting result is taken.
// Reset (synchronous, rst_n low): indices, fill counts and busy flags cleared.
// Byte stores are not cleared. Depends on mur_pkg, mur_ctrl, mur_datapath.
module multichannel_uart_ring_buffers_unit #(
  parameter int CHANNELS = mur_pkg::DEF_CHANNELS,
  parameter int RX_DEPTH = mur_pkg::DEF_RX_DEPTH,
  parameter int TX_DEPTH = mur_pkg::DEF_TX_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mur_pkg::OP_W-1:0]      in_op,
  input  logic [mur_pkg::CHAN_W-1:0]    in_channel,
  input  logic [mur_pkg::BYTE_W-1:0]    in_data_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mur_pkg::BYTE_W-1:0]    out_data_out,
  output logic [mur_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_send_valid,
  output logic [mur_pkg::COUNT_W-1:0]   out_rx_count,
  output logic [mur_pkg::COUNT_W-1:0]   out_tx_count
);

  mur_pkg::cmd_t     cmd;
  mur_pkg::dp_stat_t stat;

  // sequencing
  mur_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // stores, indices and result register
  mur_datapath #(
    .CHANNELS (CHANNELS),
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_op          (in_op),
    .in_channel     (in_channel),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_send_valid (out_send_valid),
    .out_rx_count   (out_rx_count),
    .out_tx_count   (out_tx_count)
  );

endmodule
